// ===== rtl/rtam_pkg.sv =====
// Shared types and constants for the raster-to-tile address mapper.
`timescale 1ns / 1ps

package rtam_pkg;

    // Default limits on the image and tile dimensions.
    localparam int MAX_IMAGE_DIM_DEF = 4096;
    localparam int MAX_TILE_DIM_DEF  = 256;

    // Configuration register widths and the widths of the register address and data.
    localparam int CFG_IMG_W  = 13;
    localparam int CFG_TILE_W = 9;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Register values after reset.
    localparam logic [CFG_IMG_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [CFG_IMG_W-1:0]  IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [CFG_TILE_W-1:0] TILE_WIDTH_RST   = 9'd16;
    localparam logic [CFG_TILE_W-1:0] TILE_HEIGHT_RST  = 9'd16;

    // Stream payload widths.
    localparam int COMP_W     = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;
    localparam int INDEX_W    = 24;
    localparam int OFFSET_W   = 16;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_TILE_WIDTH   = 2'd2,
        REG_TILE_HEIGHT  = 2'd3
    } t_reg_idx;

    // One result item as held in the output stage.
    typedef struct packed {
        logic                tile_last;
        logic [OFFSET_W-1:0] tile_offset;
        logic [INDEX_W-1:0]  tile_index;
        logic [COMP_W-1:0]   blue;
        logic [COMP_W-1:0]   green;
        logic [COMP_W-1:0]   red;
    } t_result;

endpackage

// ===== rtl/raster_to_tile_address_mapper.sv =====
// Raster-to-tile address mapper: pixel counters, tile addressing and output stage.
// Each accepted pixel of a whole tile has its result registered in the output stage.
// Throughput: one pixel per clock while s_tready is high; the counters and address
// arithmetic (one small multiply for the offset) are combinational.
// A two-entry output stage (result register plus skid register) keeps s_tready
// high while one result waits downstream.
// Reset is synchronous and active low: registers return to 640x480 with 16x16
// tiles, all counters to zero and the output stage empties.
`timescale 1ns / 1ps

module raster_to_tile_address_mapper #(
    parameter int MAX_IMAGE_DIM = rtam_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_TILE_DIM  = rtam_pkg::MAX_TILE_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rtam_pkg::IN_DATA_W-1:0]  s_tdata,   // red, green, blue
    // Tiled pixel output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rtam_pkg::OUT_DATA_W-1:0] m_tdata,   // red, green, blue, tile_index,
                                                       // tile_offset
    output logic                            m_tlast,   // tile_last
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtam_pkg::ADDR_W-1:0]     paddr,
    input  logic [rtam_pkg::DATA_W-1:0]     pwdata,
    output logic [rtam_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int IMG_CW  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int TILE_CW = $clog2(MAX_TILE_DIM + 1);
    localparam int SUM_W   = ((IMG_CW > TILE_CW) ? IMG_CW : TILE_CW) + 1;
    localparam int PROD_W  = 2 * TILE_CW;

    // Configuration registers.
    logic [rtam_pkg::CFG_IMG_W-1:0]  r_image_width;
    logic [rtam_pkg::CFG_IMG_W-1:0]  r_image_height;
    logic [rtam_pkg::CFG_TILE_W-1:0] r_tile_width;
    logic [rtam_pkg::CFG_TILE_W-1:0] r_tile_height;
    logic                            cfg_write;

    // Clamped dimensions.
    logic [31:0]         w32, h32, tw32, th32;
    logic [IMG_CW-1:0]   dim_w, dim_h;
    logic [TILE_CW-1:0]  dim_tw, dim_th;

    // Position counters.
    logic [IMG_CW-1:0]            r_pix_col, n_pix_col;
    logic [IMG_CW-1:0]            r_pix_row, n_pix_row;
    logic [TILE_CW-1:0]           r_col_in_tile, n_col_in_tile;
    logic [TILE_CW-1:0]           r_row_in_tile, n_row_in_tile;
    logic [IMG_CW-1:0]            r_tile_col, n_tile_col;
    logic [IMG_CW-1:0]            r_tile_x0, n_tile_x0;
    logic [IMG_CW-1:0]            r_tile_y0, n_tile_y0;
    logic [rtam_pkg::INDEX_W-1:0] r_row_base, n_row_base;

    // Per-pixel results.
    logic               in_accept;
    logic               tile_fits;
    logic [PROD_W-1:0]  offset_prod;
    rtam_pkg::t_result  result;

    // Output stage.
    rtam_pkg::t_result  r_out, r_skid;
    logic               r_out_valid, r_skid_valid;
    logic               out_take, push;

    // Register writes complete in the access phase; pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rtam_pkg::IMAGE_WIDTH_RST;
            r_image_height <= rtam_pkg::IMAGE_HEIGHT_RST;
            r_tile_width   <= rtam_pkg::TILE_WIDTH_RST;
            r_tile_height  <= rtam_pkg::TILE_HEIGHT_RST;
        end else if (cfg_write) begin
            case (rtam_pkg::t_reg_idx'(paddr[3:2]))
                rtam_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= pwdata[rtam_pkg::CFG_IMG_W-1:0];
                end
                rtam_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= pwdata[rtam_pkg::CFG_IMG_W-1:0];
                end
                rtam_pkg::REG_TILE_WIDTH: begin
                    r_tile_width <= pwdata[rtam_pkg::CFG_TILE_W-1:0];
                end
                rtam_pkg::REG_TILE_HEIGHT: begin
                    r_tile_height <= pwdata[rtam_pkg::CFG_TILE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (rtam_pkg::t_reg_idx'(paddr[3:2]))
            rtam_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            rtam_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            rtam_pkg::REG_TILE_WIDTH:   prdata = 32'(r_tile_width);
            rtam_pkg::REG_TILE_HEIGHT:  prdata = 32'(r_tile_height);
            default:                    prdata = '0;
        endcase
    end

    // A zero dimension acts as one and an oversized one is held at its limit.
    always_comb begin
        w32  = 32'(r_image_width);
        h32  = 32'(r_image_height);
        tw32 = 32'(r_tile_width);
        th32 = 32'(r_tile_height);
        if (w32 == 32'd0) w32 = 32'd1;
        else if (w32 > 32'(MAX_IMAGE_DIM)) w32 = 32'(MAX_IMAGE_DIM);
        if (h32 == 32'd0) h32 = 32'd1;
        else if (h32 > 32'(MAX_IMAGE_DIM)) h32 = 32'(MAX_IMAGE_DIM);
        if (tw32 == 32'd0) tw32 = 32'd1;
        else if (tw32 > 32'(MAX_TILE_DIM)) tw32 = 32'(MAX_TILE_DIM);
        if (th32 == 32'd0) th32 = 32'd1;
        else if (th32 > 32'(MAX_TILE_DIM)) th32 = 32'(MAX_TILE_DIM);
        dim_w  = w32[IMG_CW-1:0];
        dim_h  = h32[IMG_CW-1:0];
        dim_tw = tw32[TILE_CW-1:0];
        dim_th = th32[TILE_CW-1:0];
    end

    assign s_tready  = !r_skid_valid;
    assign in_accept = s_tvalid && s_tready;

    // The current tile is whole when its far edges stay inside the image.
    assign tile_fits = (SUM_W'(r_tile_x0) + SUM_W'(dim_tw) <= SUM_W'(dim_w)) &&
                       (SUM_W'(r_tile_y0) + SUM_W'(dim_th) <= SUM_W'(dim_h));

    // Tile address, offset and end-of-tile flag for the pixel at the input.
    assign offset_prod = PROD_W'(r_row_in_tile) * PROD_W'(dim_tw);

    always_comb begin
        result.red         = s_tdata[7:0];
        result.green       = s_tdata[15:8];
        result.blue        = s_tdata[23:16];
        result.tile_index  = r_row_base + rtam_pkg::INDEX_W'(r_tile_col);
        result.tile_offset = rtam_pkg::OFFSET_W'(offset_prod + PROD_W'(r_col_in_tile));
        result.tile_last   = (r_col_in_tile == dim_tw - 1'b1) &&
                             (r_row_in_tile == dim_th - 1'b1);
    end

    // Counter advance for one accepted pixel. The row base grows by the number
    // of whole tiles in a row, which is the tile column reached at a row end.
    always_comb begin
        n_pix_col     = r_pix_col;
        n_pix_row     = r_pix_row;
        n_col_in_tile = r_col_in_tile;
        n_row_in_tile = r_row_in_tile;
        n_tile_col    = r_tile_col;
        n_tile_x0     = r_tile_x0;
        n_tile_y0     = r_tile_y0;
        n_row_base    = r_row_base;
        if (in_accept) begin
            n_col_in_tile = r_col_in_tile + 1'b1;
            if ((TILE_CW + 1)'(r_col_in_tile) + 1'b1 >= (TILE_CW + 1)'(dim_tw)) begin
                n_col_in_tile = '0;
                n_tile_col    = r_tile_col + 1'b1;
                n_tile_x0     = r_pix_col + 1'b1;
            end
            n_pix_col = r_pix_col + 1'b1;
            if ((IMG_CW + 1)'(r_pix_col) + 1'b1 >= (IMG_CW + 1)'(dim_w)) begin
                n_pix_col     = '0;
                n_col_in_tile = '0;
                n_row_in_tile = r_row_in_tile + 1'b1;
                if ((TILE_CW + 1)'(r_row_in_tile) + 1'b1 >= (TILE_CW + 1)'(dim_th)) begin
                    n_row_in_tile = '0;
                    n_row_base    = r_row_base + rtam_pkg::INDEX_W'(n_tile_col);
                    n_tile_y0     = r_pix_row + 1'b1;
                end
                n_tile_col    = '0;
                n_tile_x0     = '0;
                n_pix_row = r_pix_row + 1'b1;
                if ((IMG_CW + 1)'(r_pix_row) + 1'b1 >= (IMG_CW + 1)'(dim_h)) begin
                    n_pix_row     = '0;
                    n_row_in_tile = '0;
                    n_row_base    = '0;
                    n_tile_y0     = '0;
                end
            end
        end
    end

    // Counters restart on reset and on every register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            r_pix_col     <= '0;
            r_pix_row     <= '0;
            r_col_in_tile <= '0;
            r_row_in_tile <= '0;
            r_tile_col    <= '0;
            r_tile_x0     <= '0;
            r_tile_y0     <= '0;
            r_row_base    <= '0;
        end else begin
            r_pix_col     <= n_pix_col;
            r_pix_row     <= n_pix_row;
            r_col_in_tile <= n_col_in_tile;
            r_row_in_tile <= n_row_in_tile;
            r_tile_col    <= n_tile_col;
            r_tile_x0     <= n_tile_x0;
            r_tile_y0     <= n_tile_y0;
            r_row_base    <= n_row_base;
        end
    end

    // Output stage: a result register backed by a skid register.
    assign out_take = r_out_valid && m_tready;
    assign push     = in_accept && tile_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !out_take) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out.tile_offset, r_out.tile_index,
                       r_out.blue, r_out.green, r_out.red};
    assign m_tlast  = r_out.tile_last;

    // A held result in the skid register always has one ahead of it.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // A skid entry moves up when the front result is taken.
    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_tready) |=> (m_tvalid && !r_skid_valid))
        else $error("skid entry was not moved to the output register");

    // Position inside the tile stays below the tile size.
    a_tile_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_in_tile < dim_tw) && (r_row_in_tile < dim_th))
        else $error("position inside tile out of range");

    // Image position stays inside the frame.
    a_pix_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_col < dim_w) && (r_pix_row < dim_h))
        else $error("pixel position outside the frame");

endmodule
